[design/ocu_pkg.sv]
// ocu_pkg: shared types, widths and tables for the orbit camera update block
// no dependencies; used by ocu_cordic and orbit_camera_update_top
`timescale 1ns / 1ps

package ocu_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    MODE_ORBIT = 2'd0,
    MODE_PAN   = 2'd1,
    MODE_RESET = 2'd2
  } mode_t;

  // sine and cosine in q1.14, clamped to +/-1.0
  localparam int TRIG_W   = 16;
  localparam int TRIG_ONE = 16384;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_q;
    logic signed [TRIG_W-1:0] cos_q;
  } trig_t;

  // cordic datapath: q30 vector, angle with 32 bits per turn
  localparam int XY_W       = 33;
  localparam int Z_W        = 34;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W     = 30;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // shared multiplier and delta accumulator
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 30;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;
  localparam int ACC_FRAC = 28;

  // arctangent of 2^-i in 32-bit turn units
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up from q30 to q1.14 and clamp to +/-1.0
  function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0]    s;
    logic signed [XY_W-16:0] r;
    logic signed [TRIG_W-1:0] q;
    s = (XY_W+1)'(v) + (XY_W+1)'(32768);
    r = s[XY_W:16];
    if (r > (XY_W-15)'(TRIG_ONE)) begin
      q = TRIG_W'(TRIG_ONE);
    end else if (r < -(XY_W-15)'(TRIG_ONE)) begin
      q = -TRIG_W'(TRIG_ONE);
    end else begin
      q = r[TRIG_W-1:0];
    end
    return q;
  endfunction

endpackage

[design/ocu_cordic.sv]
// ocu_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// depends on ocu_pkg (widths, arctangent table, q1.14 rounding)
`timescale 1ns / 1ps

module ocu_cordic #(
  parameter int STEPS      = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output ocu_pkg::trig_t        trig
);

  localparam int CNT_W  = $clog2(STEPS);
  localparam int ZERO_W = 32 - ANGLE_BITS;

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_FLIP, C_ROUND} cstate_t;

  cstate_t                            state;
  logic [CNT_W-1:0]                   cnt;
  logic                               flip;
  logic signed [ocu_pkg::XY_W-1:0]    x;
  logic signed [ocu_pkg::XY_W-1:0]    y;
  logic signed [ocu_pkg::Z_W-1:0]     z;

  logic [31:0]                        u_c;
  logic [31:0]                        quarter;
  logic                               flip_c;
  logic [31:0]                        u_f;
  logic signed [ocu_pkg::Z_W-1:0]     z0;
  logic signed [ocu_pkg::XY_W-1:0]    x_sh;
  logic signed [ocu_pkg::XY_W-1:0]    y_sh;
  logic signed [ocu_pkg::Z_W-1:0]     atan_z;
  logic signed [ocu_pkg::XY_W-1:0]    x_next;
  logic signed [ocu_pkg::XY_W-1:0]    y_next;
  logic signed [ocu_pkg::Z_W-1:0]     z_next;

  // fold the angle into the right half plane, then one micro-rotation
  always_comb begin
    u_c     = {angle, {ZERO_W{1'b0}}};
    quarter = u_c + 32'h4000_0000;
    flip_c  = quarter[31];
    u_f     = flip_c ? {~u_c[31], u_c[30:0]} : u_c;
    z0      = ocu_pkg::Z_W'(signed'(u_f));
    x_sh    = x >>> cnt;
    y_sh    = y >>> cnt;
    atan_z  = signed'(ocu_pkg::Z_W'(ocu_pkg::atan_turn(ocu_pkg::ATAN_IDX_W'(cnt))));
    if (z[ocu_pkg::Z_W-1]) begin
      x_next = x + y_sh;
      y_next = y - x_sh;
      z_next = z + atan_z;
    end else begin
      x_next = x - y_sh;
      y_next = y + x_sh;
      z_next = z - atan_z;
    end
  end

  // sequencer and vector registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            x     <= ocu_pkg::CORDIC_GAIN_Q30;
            y     <= '0;
            z     <= z0;
            flip  <= flip_c;
            cnt   <= '0;
            state <= C_ITER;
          end
        end
        C_ITER: begin
          x <= x_next;
          y <= y_next;
          z <= z_next;
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= C_FLIP;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        C_FLIP: begin
          if (flip) begin
            x <= -x;
            y <= -y;
          end
          state <= C_ROUND;
        end
        C_ROUND: begin
          trig.sin_q <= ocu_pkg::to_q14(y);
          trig.cos_q <= ocu_pkg::to_q14(x);
          done       <= 1'b1;
          state      <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // start is only honoured when idle, so a busy start is a sequencing slip
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == C_IDLE))
    else $error("cordic start while busy");

  // done follows the rounding cycle and nothing else
  a_done_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == C_ROUND)
    else $error("cordic done without rounding");

  // results stay within +/-1.0 in q1.14
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (trig.sin_q <= 16'sd16384 && trig.sin_q >= -16'sd16384 &&
              trig.cos_q <= 16'sd16384 && trig.cos_q >= -16'sd16384))
    else $error("cordic result out of range");

endmodule

[design/orbit_camera_update_top.sv]
// orbit camera update: yaw, pitch and focus point, one result per transfer.
// orbit, reset and the unused mode: the transfer moves to the completion state, which then loads the result.
// pan: two runs on one shared cordic (yaw, then pitch), then the multiply steps M_SYSP to
// M_MVY and the completion state that loads the result.
// the next transfer is taken once the result is loaded; an unaccepted result holds it off.
// sync reset clears the sequencer, valid flags, angles and focus point.
`timescale 1ns / 1ps

module orbit_camera_update_top #(
  parameter int CORDIC_STEPS  = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] yaw_step,
  input  logic signed [15:0] pitch_step,
  input  logic signed [31:0] pan_right,
  input  logic signed [31:0] pan_up,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [15:0]        yaw_out,
  output logic signed [14:0] pitch_out,
  output logic signed [31:0] focus_x,
  output logic signed [31:0] focus_y,
  output logic signed [31:0] focus_z
);

  localparam int PS_W  = (ANGLE_BITS > 16 ? ANGLE_BITS : 16) + 1;
  localparam int YX_W  = ANGLE_BITS > 16 ? ANGLE_BITS : 16;
  localparam int PX_W  = ANGLE_BITS > 15 ? ANGLE_BITS : 15;
  localparam int FX_W  = POSITION_BITS > 32 ? POSITION_BITS : 32;
  localparam int DQ_W  = ocu_pkg::ACC_W - ocu_pkg::ACC_FRAC;
  localparam int SUM_W = (POSITION_BITS > DQ_W ? POSITION_BITS : DQ_W) + 1;
  localparam int TW    = ocu_pkg::TRIG_W;
  localparam int AW    = ocu_pkg::MUL_A_W;
  localparam int BW    = ocu_pkg::MUL_B_W;

  localparam logic signed [PS_W-1:0] PITCH_LIMIT =
    PS_W'((89 * (2 ** ANGLE_BITS) + 180) / 360);
  localparam logic signed [ocu_pkg::ACC_W-1:0] ROUND_HALF =
    ocu_pkg::ACC_W'(2 ** (ocu_pkg::ACC_FRAC - 1));
  localparam logic signed [SUM_W-1:0] POS_ONE = SUM_W'(1);
  localparam logic signed [SUM_W-1:0] POS_MAX = (POS_ONE <<< (POSITION_BITS - 1)) - POS_ONE;
  localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

  typedef enum logic [2:0] {S_IDLE, S_CYAW, S_CPIT, S_MAC, S_DONE} state_t;

  // the steps of the multiply and accumulate sequence, in order
  typedef enum logic [3:0] {
    M_SYSP, M_CYSP, M_DXCY, M_DYSS, M_DXSY, M_DYCS, M_DYCP, M_MVZ, M_MVY
  } mstep_t;

  state_t                            state;
  mstep_t                            step;
  mstep_t                            step_next;

  logic [ANGLE_BITS-1:0]             yaw;
  logic signed [ANGLE_BITS-1:0]      pitch;
  logic signed [POSITION_BITS-1:0]   px;
  logic signed [POSITION_BITS-1:0]   py;
  logic signed [POSITION_BITS-1:0]   pz;

  logic signed [31:0]                dx;
  logic signed [31:0]                dy;
  logic signed [TW-1:0]              sy;
  logic signed [TW-1:0]              cy;
  logic signed [TW-1:0]              sp;
  logic signed [TW-1:0]              cp;
  logic signed [BW-1:0]              ssp;
  logic signed [BW-1:0]              csp;
  logic signed [ocu_pkg::PROD_W-1:0] prod;
  logic signed [ocu_pkg::ACC_W-1:0]  acc;

  logic                              cs_start;
  logic [ANGLE_BITS-1:0]             cs_angle;
  logic                              cs_done;
  ocu_pkg::trig_t                    cs_trig;

  logic                              item_xfer;
  logic [ANGLE_BITS-1:0]             yaw_sum;
  logic signed [PS_W-1:0]            pitch_sum;
  logic signed [PS_W-1:0]            pitch_clamp;
  logic signed [AW-1:0]              mul_a;
  logic signed [BW-1:0]              mul_b;
  logic signed [ocu_pkg::PROD_W-1:0] prod_c;
  logic signed [ocu_pkg::ACC_W-1:0]  prod_sh;
  logic signed [POSITION_BITS-1:0]   mv_pos;
  logic signed [SUM_W-1:0]           mv_sum;
  logic signed [POSITION_BITS-1:0]   mv_res;
  logic signed [FX_W-1:0]            px_wide;
  logic signed [FX_W-1:0]            py_wide;
  logic signed [FX_W-1:0]            pz_wide;
  logic [YX_W-1:0]                   yaw_wide;
  logic signed [PX_W-1:0]            pitch_wide;

  assign item_ready = (state == S_IDLE);
  assign item_xfer  = item_valid && item_ready;

  // shared cordic for yaw then pitch
  ocu_cordic #(
    .STEPS      (CORDIC_STEPS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cs_start),
    .angle (cs_angle),
    .done  (cs_done),
    .trig  (cs_trig)
  );

  // orbit arithmetic: wrapping yaw, clamped pitch
  always_comb begin
    yaw_sum   = yaw + ANGLE_BITS'(yaw_step);
    pitch_sum = PS_W'(pitch) + PS_W'(pitch_step);
    if (pitch_sum > PITCH_LIMIT) begin
      pitch_clamp = PITCH_LIMIT;
    end else if (pitch_sum < -PITCH_LIMIT) begin
      pitch_clamp = -PITCH_LIMIT;
    end else begin
      pitch_clamp = pitch_sum;
    end
  end

  // multiplier operands, mover target and step sequence
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mv_pos    = py;
    step_next = step;
    unique case (step)
      M_SYSP: begin
        mul_a = AW'(sy);
        mul_b = BW'(sp);
        step_next = M_CYSP;
      end
      M_CYSP: begin
        mul_a = AW'(cy);
        mul_b = BW'(sp);
        step_next = M_DXCY;
      end
      M_DXCY: begin
        mul_a = dx;
        mul_b = BW'(cy);
        step_next = M_DYSS;
      end
      M_DYSS: begin
        mul_a = dy;
        mul_b = ssp;
        step_next = M_DXSY;
      end
      M_DXSY: begin
        mul_a = dx;
        mul_b = BW'(sy);
        step_next = M_DYCS;
      end
      M_DYCS: begin
        mul_a  = dy;
        mul_b  = csp;
        mv_pos = px;
        step_next = M_DYCP;
      end
      M_DYCP: begin
        mul_a = dy;
        mul_b = BW'(cp);
        step_next = M_MVZ;
      end
      M_MVZ: begin
        mv_pos = pz;
        step_next = M_MVY;
      end
      M_MVY: begin
        mv_pos = py;
        step_next = M_SYSP;
      end
      default: step_next = M_SYSP;
    endcase
  end

  // product, scaled product and saturating move of one coordinate
  always_comb begin
    prod_c  = ocu_pkg::PROD_W'(mul_a) * ocu_pkg::PROD_W'(mul_b);
    prod_sh = prod <<< 14;
    mv_sum  = SUM_W'(mv_pos) +
              SUM_W'(signed'(acc[ocu_pkg::ACC_W-1:ocu_pkg::ACC_FRAC]));
    if (mv_sum > POS_MAX) begin
      mv_res = POS_MAX[POSITION_BITS-1:0];
    end else if (mv_sum < POS_MIN) begin
      mv_res = POS_MIN[POSITION_BITS-1:0];
    end else begin
      mv_res = mv_sum[POSITION_BITS-1:0];
    end
  end

  // result field views of the state
  always_comb begin
    yaw_wide   = YX_W'(yaw);
    pitch_wide = PX_W'(pitch);
    px_wide    = FX_W'(px);
    py_wide    = FX_W'(py);
    pz_wide    = FX_W'(pz);
  end

  // sequencer, camera state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= M_SYSP;
      cs_start     <= 1'b0;
      result_valid <= 1'b0;
      yaw          <= '0;
      pitch        <= '0;
      px           <= '0;
      py           <= '0;
      pz           <= '0;
    end else begin
      cs_start <= 1'b0;
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_xfer) begin
            unique case (mode)
              ocu_pkg::MODE_ORBIT: begin
                yaw   <= yaw_sum;
                pitch <= pitch_clamp[ANGLE_BITS-1:0];
                state <= S_DONE;
              end
              ocu_pkg::MODE_PAN: begin
                dx       <= pan_right;
                dy       <= pan_up;
                cs_start <= 1'b1;
                cs_angle <= yaw;
                state    <= S_CYAW;
              end
              ocu_pkg::MODE_RESET: begin
                yaw   <= '0;
                pitch <= '0;
                px    <= '0;
                py    <= '0;
                pz    <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CYAW: begin
          if (cs_done) begin
            sy       <= cs_trig.sin_q;
            cy       <= cs_trig.cos_q;
            cs_start <= 1'b1;
            cs_angle <= pitch;
            state    <= S_CPIT;
          end
        end
        S_CPIT: begin
          if (cs_done) begin
            sp    <= cs_trig.sin_q;
            cp    <= cs_trig.cos_q;
            step  <= M_SYSP;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          prod <= prod_c;
          step <= step_next;
          unique case (step)
            M_SYSP: ;
            M_CYSP: ssp <= prod[BW-1:0];
            M_DXCY: csp <= prod[BW-1:0];
            M_DYSS: acc <= prod_sh + ROUND_HALF;
            M_DXSY: acc <= acc + prod;
            M_DYCS: begin
              px  <= mv_res;
              acc <= ROUND_HALF - prod_sh;
            end
            M_DYCP: acc <= acc + prod;
            M_MVZ: begin
              pz  <= mv_res;
              acc <= prod_sh + ROUND_HALF;
            end
            M_MVY: begin
              py    <= mv_res;
              state <= S_DONE;
            end
            default: ;
          endcase
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            yaw_out      <= yaw_wide[15:0];
            pitch_out    <= pitch_wide[14:0];
            focus_x      <= px_wide[31:0];
            focus_y      <= py_wide[31:0];
            focus_z      <= pz_wide[31:0];
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pitch never leaves the clamp range
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (PS_W'(pitch) <= PITCH_LIMIT) && (PS_W'(pitch) >= -PITCH_LIMIT))
    else $error("pitch outside clamp range");

  // a pan transfer launches the yaw cordic run
  a_pan_start: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && mode == ocu_pkg::MODE_PAN) |=> (cs_start && state == S_CYAW))
    else $error("pan did not start cordic");

  // cordic results only arrive while they are awaited
  a_cordic_awaited: assert property (@(posedge clk) disable iff (rst)
    cs_done |-> (state == S_CYAW || state == S_CPIT))
    else $error("unexpected cordic result");

  // a new result is only raised from the completion state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");

endmodule
